FILE: rtl/triangle_plane_clipper_core_defines.svh
// Assertion macros shared by the triangle plane clipper RTL.
`ifndef TRIANGLE_PLANE_CLIPPER_CORE_DEFINES_SVH
`define TRIANGLE_PLANE_CLIPPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");
`define TPC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: sequence check failed");
`else
`define TPC_ASSERT(lbl, cond)
`define TPC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/tpc_pkg.sv
// Shared types and constants of the triangle plane clipper.
package tpc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_FIELDS     = 6;
  localparam int NUM_AXES       = 3;
  localparam int DIST_W         = 64;

  typedef enum logic [2:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_POS_Z  = 3'd2,
    REG_NORM_X = 3'd3,
    REG_NORM_Y = 3'd4,
    REG_NORM_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIST_WAIT,
    ST_CLASS,
    ST_DIV_INIT,
    ST_DIV,
    ST_INTERP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic [1:0] load_slot;
    logic       dist_mul;
    logic [1:0] vi;
    logic [1:0] ax;
    logic       div_init;
    logic       div_step;
    logic       interp_mul;
    logic       sel;
    logic [2:0] field;
    logic       emit;
    logic [2:0] eidx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] n_inside;
  } dp_stat_t;

endpackage

FILE: rtl/tpc_regs.sv
// Plane configuration registers behind the APB-style port.
module tpc_regs #(
  parameter int DATA_WIDTH = tpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = tpc_pkg::FRAC_BITS_DEF,
  parameter int CFG_W      = 32,
  parameter int ADDR_W     = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [CFG_W-1:0]             pwdata,
  output logic [CFG_W-1:0]             prdata,
  output logic                         pready,
  output logic signed [DATA_WIDTH-1:0] plane_pos [tpc_pkg::NUM_AXES],
  output logic signed [DATA_WIDTH-1:0] plane_norm [tpc_pkg::NUM_AXES]
);
  import tpc_pkg::*;

  localparam int IDX_LSB = (CFG_W > 32) ? 3 : 2;
  localparam logic signed [DATA_WIDTH-1:0] ONE_R = DATA_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] NEAR_R =
    DATA_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic signed [DATA_WIDTH-1:0] pos_r [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] norm_r [NUM_AXES];
  logic [2:0]                   idx;
  logic                         wr_en;
  logic signed [DATA_WIDTH-1:0] rd_val;

  assign idx    = paddr[ADDR_W-1:IDX_LSB];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0]  <= '0;
      pos_r[1]  <= '0;
      pos_r[2]  <= NEAR_R;
      norm_r[0] <= '0;
      norm_r[1] <= '0;
      norm_r[2] <= ONE_R;
    end else if (wr_en) begin
      unique case (idx)
        REG_POS_X:  pos_r[0]  <= pwdata[DATA_WIDTH-1:0];
        REG_POS_Y:  pos_r[1]  <= pwdata[DATA_WIDTH-1:0];
        REG_POS_Z:  pos_r[2]  <= pwdata[DATA_WIDTH-1:0];
        REG_NORM_X: norm_r[0] <= pwdata[DATA_WIDTH-1:0];
        REG_NORM_Y: norm_r[1] <= pwdata[DATA_WIDTH-1:0];
        REG_NORM_Z: norm_r[2] <= pwdata[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POS_X:  rd_val = pos_r[0];
      REG_POS_Y:  rd_val = pos_r[1];
      REG_POS_Z:  rd_val = pos_r[2];
      REG_NORM_X: rd_val = norm_r[0];
      REG_NORM_Y: rd_val = norm_r[1];
      REG_NORM_Z: rd_val = norm_r[2];
      default:    rd_val = '0;
    endcase
  end

  assign prdata     = CFG_W'(rd_val);
  assign plane_pos  = pos_r;
  assign plane_norm = norm_r;

endmodule

FILE: rtl/tpc_ctrl.sv
// Sequencer that steps the clipper datapath through one triangle.
module tpc_ctrl #(
  parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tpc_pkg::dp_stat_t  stat,
  output tpc_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import tpc_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         vi_r, vi_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic               sel_r, sel_nxt;
  logic [1:0]         vcount_r, vcount_nxt;
  logic               accept;
  logic [2:0]         emit_last;

  assign accept    = start && (state_r == ST_IDLE);
  assign emit_last = (stat.n_inside == 2'd2) ? 3'd5 : 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      vi_r     <= '0;
      ax_r     <= '0;
      sel_r    <= 1'b0;
      vcount_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      vi_r     <= vi_nxt;
      ax_r     <= ax_nxt;
      sel_r    <= sel_nxt;
      vcount_r <= vcount_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    vi_nxt     = vi_r;
    ax_nxt     = ax_r;
    sel_nxt    = sel_r;
    vcount_nxt = vcount_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (vcount_r == 2'd2) begin
            vcount_nxt = '0;
            vi_nxt     = '0;
            ax_nxt     = '0;
            state_nxt  = ST_DIST;
          end else begin
            vcount_nxt = vcount_r + 2'd1;
          end
        end
      end
      ST_DIST: begin
        if (ax_r == 2'd2) begin
          ax_nxt = '0;
          vi_nxt = vi_r + 2'd1;
          if (vi_r == 2'd2) begin
            state_nxt = ST_DIST_WAIT;
          end
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      ST_DIST_WAIT: begin
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        cnt_nxt = '0;
        sel_nxt = 1'b0;
        unique case (stat.n_inside)
          2'd0:    state_nxt = ST_IDLE;
          2'd3:    state_nxt = ST_EMIT;
          default: state_nxt = ST_DIV_INIT;
        endcase
      end
      ST_DIV_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_INTERP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_INTERP: begin
        if (cnt_r == CNT_W'(NUM_FIELDS)) begin
          cnt_nxt = '0;
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = ST_DIV_INIT;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (cnt_r[2:0] == emit_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_slot  = vcount_r;
    cmd.vi         = vi_r;
    cmd.ax         = ax_r;
    cmd.sel        = sel_r;
    cmd.field      = cnt_r[2:0];
    cmd.eidx       = cnt_r[2:0];
    busy           = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:     cmd.load       = accept;
      ST_DIST:     cmd.dist_mul   = 1'b1;
      ST_DIV_INIT: cmd.div_init   = 1'b1;
      ST_DIV:      cmd.div_step   = 1'b1;
      ST_INTERP:   cmd.interp_mul = (cnt_r != CNT_W'(NUM_FIELDS));
      ST_EMIT:     cmd.emit       = 1'b1;
      default:     ;
    endcase
  end

endmodule

FILE: rtl/tpc_dp.sv
// Datapath: vertex store, shared multiplier, divider and result mux.
module tpc_dp #(
  parameter int DATA_WIDTH = tpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = tpc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpc_pkg::dp_cmd_t             cmd,
  output tpc_pkg::dp_stat_t            stat,
  input  logic signed [DATA_WIDTH-1:0] in_fields [tpc_pkg::NUM_FIELDS],
  input  logic signed [DATA_WIDTH-1:0] plane_pos [tpc_pkg::NUM_AXES],
  input  logic signed [DATA_WIDTH-1:0] plane_norm [tpc_pkg::NUM_AXES],
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_fields [tpc_pkg::NUM_FIELDS],
  output logic                         out_tri_index,
  output logic [1:0]                   out_corner,
  output logic [1:0]                   out_tri_count,
  output logic                         out_last
);
  import tpc_pkg::*;

  localparam int MW = ((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS) + 1;
  localparam int PW = 2 * MW;
  localparam int EW = ((PW > DIST_W) ? PW : DIST_W) + 1;
  localparam logic signed [EW-1:0] TERM_LIM = EW'(64'd1 << 60);
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  logic signed [DATA_WIDTH-1:0] vtx_r [3][NUM_FIELDS];
  logic signed [DATA_WIDTH-1:0] res_r [2][NUM_FIELDS];
  logic signed [DIST_W-1:0]     d_r [3];
  logic signed [DIST_W-1:0]     rem_r;
  logic signed [DIST_W-1:0]     den_r;
  logic [FRAC_BITS-1:0]         t_r;
  logic signed [PW-1:0]         prod_r;
  logic                         dpend_r;
  logic                         dfirst_r;
  logic [1:0]                   dvi_r;
  logic                         ipend_r;
  logic [2:0]                   ifield_r;
  logic                         valid_r;
  logic signed [DATA_WIDTH-1:0] of_r [NUM_FIELDS];
  logic                         otri_r;
  logic [1:0]                   ocorner_r;
  logic [1:0]                   ocount_r;
  logic                         olast_r;

  logic [2:0]                   ins;
  logic [1:0]                   p_i, q_i, o0_i, o1_i, iv, ov;
  logic signed [MW-1:0]         mul_a, mul_b;
  logic signed [EW-1:0]         shifted;
  logic signed [EW-1:0]         term;
  logic signed [EW-1:0]         isum;
  logic signed [DATA_WIDTH-1:0] isat;
  logic [DIST_W:0]              r2;
  logic [DIST_W:0]              r2_sub;
  logic signed [DATA_WIDTH-1:0] sel_f [NUM_FIELDS];
  logic                         sel_tri;
  logic [1:0]                   sel_corner;
  logic                         sel_last;
  logic [1:0]                   src;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ins[i] = !d_r[i][DIST_W-1];
    end
  end

  assign stat.n_inside = 2'($countones(ins));
  assign p_i  = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
  assign q_i  = (ins[0] && ins[1]) ? 2'd1 : 2'd2;
  assign o0_i = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
  assign o1_i = (!ins[0] && !ins[1]) ? 2'd1 : 2'd2;
  assign iv   = (stat.n_inside == 2'd2 && cmd.sel) ? q_i : p_i;
  assign ov   = (stat.n_inside == 2'd1 && cmd.sel) ? o1_i : o0_i;

  always_comb begin
    if (cmd.dist_mul) begin
      mul_a = MW'(vtx_r[cmd.vi][cmd.ax]) - MW'(plane_pos[cmd.ax]);
      mul_b = MW'(plane_norm[cmd.ax]);
    end else begin
      mul_a = MW'(vtx_r[ov][cmd.field]) - MW'(vtx_r[iv][cmd.field]);
      mul_b = signed'(MW'(t_r));
    end
  end

  always_comb begin
    shifted = EW'(prod_r >>> FRAC_BITS);
    if (shifted > TERM_LIM) begin
      term = TERM_LIM;
    end else if (shifted < -TERM_LIM) begin
      term = -TERM_LIM;
    end else begin
      term = shifted;
    end
    isum = EW'(vtx_r[iv][ifield_r]) + shifted;
    if (isum > SAT_HI) begin
      isat = SAT_HI[DATA_WIDTH-1:0];
    end else if (isum < SAT_LO) begin
      isat = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      isat = isum[DATA_WIDTH-1:0];
    end
  end

  assign r2     = {rem_r, 1'b0};
  assign r2_sub = r2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
        vtx_r[cmd.load_slot][k] <= in_fields[k];
      end
    end
    if (cmd.dist_mul || cmd.interp_mul) begin
      prod_r <= PW'(mul_a * mul_b);
    end
    if (dpend_r) begin
      d_r[dvi_r] <= (dfirst_r ? DIST_W'(0) : d_r[dvi_r]) + term[DIST_W-1:0];
    end
    if (ipend_r) begin
      res_r[cmd.sel][ifield_r] <= isat;
    end
    if (cmd.div_init) begin
      rem_r <= d_r[iv];
      den_r <= d_r[iv] - d_r[ov];
      t_r   <= '0;
    end else if (cmd.div_step) begin
      if (!r2_sub[DIST_W]) begin
        rem_r <= r2_sub[DIST_W-1:0];
        t_r   <= {t_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_r <= r2[DIST_W-1:0];
        t_r   <= {t_r[FRAC_BITS-2:0], 1'b0};
      end
    end
    dvi_r    <= cmd.vi;
    dfirst_r <= (cmd.ax == 2'd0);
    ifield_r <= cmd.field;
    if (cmd.emit) begin
      of_r      <= sel_f;
      otri_r    <= sel_tri;
      ocorner_r <= sel_corner;
      ocount_r  <= (stat.n_inside == 2'd2) ? 2'd2 : 2'd1;
      olast_r   <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpend_r <= 1'b0;
      ipend_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      dpend_r <= cmd.dist_mul;
      ipend_r <= cmd.interp_mul;
      valid_r <= cmd.emit;
    end
  end

  // Source code: 0 to 2 pick a held vertex.
  always_comb begin
    sel_tri    = 1'b0;
    sel_corner = cmd.eidx[1:0];
    sel_last   = (cmd.eidx == 3'd2);
    src        = p_i;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      sel_f[k] = vtx_r[p_i][k];
    end
    unique case (stat.n_inside)
      2'd3: begin
        src = cmd.eidx[1:0];
        for (int k = 0; k < NUM_FIELDS; k++) begin
          sel_f[k] = vtx_r[src][k];
        end
      end
      2'd1: begin
        if (cmd.eidx != 3'd0) begin
          for (int k = 0; k < NUM_FIELDS; k++) begin
            sel_f[k] = res_r[cmd.eidx == 3'd2][k];
          end
        end
      end
      default: begin
        sel_last = (cmd.eidx == 3'd5);
        sel_tri  = (cmd.eidx >= 3'd3);
        unique case (cmd.eidx)
          3'd0: sel_corner = 2'd0;
          3'd1: begin
            sel_corner = 2'd1;
            for (int k = 0; k < NUM_FIELDS; k++) sel_f[k] = vtx_r[q_i][k];
          end
          3'd2: begin
            sel_corner = 2'd2;
            for (int k = 0; k < NUM_FIELDS; k++) sel_f[k] = res_r[0][k];
          end
          3'd3: begin
            sel_corner = 2'd0;
            for (int k = 0; k < NUM_FIELDS; k++) sel_f[k] = vtx_r[q_i][k];
          end
          3'd4: begin
            sel_corner = 2'd1;
            for (int k = 0; k < NUM_FIELDS; k++) sel_f[k] = res_r[0][k];
          end
          3'd5: begin
            sel_corner = 2'd2;
            for (int k = 0; k < NUM_FIELDS; k++) sel_f[k] = res_r[1][k];
          end
          default: sel_corner = 2'd0;
        endcase
      end
    endcase
  end

  assign out_valid     = valid_r;
  assign out_fields    = of_r;
  assign out_tri_index = otri_r;
  assign out_corner    = ocorner_r;
  assign out_tri_count = ocount_r;
  assign out_last      = olast_r;

endmodule

FILE: rtl/triangle_plane_clipper_core.sv
// Top level of the triangle plane clipper.
// Vertices are taken one word per start pulse; every third vertex closes a
// triangle, which is clipped against the configured plane and sent out as
// zero, three or six vertex words on consecutive cycles, one per out_valid
// strobe, with no way to hold them off. The first two vertices of a triangle
// leave busy low. The third keeps busy high while its distances are summed and
// the triangle is classified, and, if any part is kept, while the intersections
// are found and the words emitted. The pace is set by the single shared
// multiplier, used once per distance term and once per interpolated field, and
// by the one-bit-per-cycle divider that finds each intersection parameter.
`include "triangle_plane_clipper_core_defines.svh"
module triangle_plane_clipper_core #(
  parameter int DATA_WIDTH = tpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = tpc_pkg::FRAC_BITS_DEF,
  parameter int CFG_W      = (DATA_WIDTH > 32) ? 64 : 32,
  parameter int ADDR_W     = (DATA_WIDTH > 32) ? 6 : 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_pos_x,
  input  logic signed [DATA_WIDTH-1:0] in_pos_y,
  input  logic signed [DATA_WIDTH-1:0] in_pos_z,
  input  logic signed [DATA_WIDTH-1:0] in_tex_u,
  input  logic signed [DATA_WIDTH-1:0] in_tex_v,
  input  logic signed [DATA_WIDTH-1:0] in_tex_w,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_y,
  output logic signed [DATA_WIDTH-1:0] out_z,
  output logic signed [DATA_WIDTH-1:0] out_u,
  output logic signed [DATA_WIDTH-1:0] out_v,
  output logic signed [DATA_WIDTH-1:0] out_w,
  output logic                         out_tri_index,
  output logic [1:0]                   out_corner,
  output logic [1:0]                   out_tri_count,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [CFG_W-1:0]             pwdata,
  output logic [CFG_W-1:0]             prdata,
  output logic                         pready
);
  import tpc_pkg::*;

  dp_cmd_t                      cmd;
  dp_stat_t                     stat;
  logic signed [DATA_WIDTH-1:0] plane_pos [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] plane_norm [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] in_fields [NUM_FIELDS];
  logic signed [DATA_WIDTH-1:0] out_fields [NUM_FIELDS];

  assign in_fields[0] = in_pos_x;
  assign in_fields[1] = in_pos_y;
  assign in_fields[2] = in_pos_z;
  assign in_fields[3] = in_tex_u;
  assign in_fields[4] = in_tex_v;
  assign in_fields[5] = in_tex_w;

  assign out_x = out_fields[0];
  assign out_y = out_fields[1];
  assign out_z = out_fields[2];
  assign out_u = out_fields[3];
  assign out_v = out_fields[4];
  assign out_w = out_fields[5];

  tpc_regs #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .CFG_W      (CFG_W),
    .ADDR_W     (ADDR_W)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .plane_pos  (plane_pos),
    .plane_norm (plane_norm)
  );

  tpc_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tpc_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_fields     (in_fields),
    .plane_pos     (plane_pos),
    .plane_norm    (plane_norm),
    .out_valid     (out_valid),
    .out_fields    (out_fields),
    .out_tri_index (out_tri_index),
    .out_corner    (out_corner),
    .out_tri_count (out_tri_count),
    .out_last      (out_last)
  );

  `TPC_ASSERT_NEXT(a_last_ends_run, out_valid && out_last, !out_valid)
  `TPC_ASSERT_NEXT(a_run_contiguous, out_valid && !out_last, out_valid)
  `TPC_ASSERT(a_single_tri_index, !(out_valid && out_tri_count == 2'd1 && out_tri_index))
  `TPC_ASSERT(a_out_while_busy, !(out_valid && !out_last && !busy))

endmodule
